/* rtl/wcrs_pkg.sv */
// shared types and constants of the warmup cosine rate schedule
package wcrs_pkg;

	localparam int unsigned TABLE_ENTRIES_DEF = 1024;
	localparam int unsigned RATE_W = 32;
	localparam int unsigned FRAC_W = 16;
	localparam int unsigned DIVD_W = 64;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [63:0] PI_Q31 = 64'd6746518852;
	localparam logic [63:0] Q31_ONE = 64'h0000_0000_8000_0000;
	localparam logic [32:0] Q32_ONE = 33'h1_0000_0000;
	localparam int unsigned HORNER_N = 7;
	localparam logic [7:0] HORNER_DIV [HORNER_N] = '{8'd182, 8'd132, 8'd90, 8'd56, 8'd30,
		8'd12, 8'd2};

	typedef enum logic [1:0] {
		PH_WARMUP = 2'd0,
		PH_DECAY  = 2'd1,
		PH_FLOOR  = 2'd2,
		PH_PEAK   = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		REG_PEAK   = 2'd0,
		REG_FLOOR  = 2'd1,
		REG_WARMUP = 2'd2,
		REG_DECAY  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [RATE_W-1:0] peak_rate;
		logic [RATE_W-1:0] floor_rate;
		logic [RATE_W-1:0] warmup_length;
		logic [RATE_W-1:0] decay_end;
	} cfg_t;

	typedef struct packed {
		phase_t            phase;
		logic [DIVD_W-1:0] dividend;
		logic [RATE_W-1:0] divisor;
	} job_t;

endpackage

/* rtl/wcrs_queue.sv */
// short job queue between the front and the back
module wcrs_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  wcrs_pkg::job_t                push_job,
	output logic                          full,
	input  logic                          pop,
	output wcrs_pkg::job_t                head,
	output logic                          empty,
	output logic [wcrs_pkg::QCNT_W-1:0]   count
);

	wcrs_pkg::job_t                ent_q [wcrs_pkg::QUEUE_DEPTH];
	logic [wcrs_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [wcrs_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [wcrs_pkg::QCNT_W-1:0]   cnt_q;
	logic                          do_push;
	logic                          do_pop;

	assign full    = (cnt_q == wcrs_pkg::QCNT_W'(wcrs_pkg::QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = ent_q[rd_ptr_q];
	assign count   = cnt_q;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!do_push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/wcrs_front.sv */
// front end: takes step beats, classifies them and builds divider jobs
module wcrs_front #(
	parameter int unsigned TABLE_ENTRIES = wcrs_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [wcrs_pkg::RATE_W-1:0]   step_number,
	output logic                          busy,
	input  wcrs_pkg::cfg_t                cfg,
	output logic                          job_valid,
	output wcrs_pkg::job_t                job,
	input  logic                          job_ready
);

	logic                          vld_s1;
	logic [wcrs_pkg::RATE_W-1:0]   step_s1;
	logic                          vld_s2;
	logic [wcrs_pkg::RATE_W-1:0]   step_s2;
	logic [wcrs_pkg::RATE_W-1:0]   d_s2;
	logic [wcrs_pkg::RATE_W-1:0]   span_s2;
	wcrs_pkg::phase_t              ph_s2;
	wcrs_pkg::phase_t              ph_next;
	logic                          s2_ld;
	logic                          s1_ld;
	logic [wcrs_pkg::DIVD_W-1:0]   warm_prod;
	logic [wcrs_pkg::DIVD_W-1:0]   decay_num;

	assign s2_ld = !vld_s2 || job_ready;
	assign s1_ld = !vld_s1 || s2_ld;
	assign busy  = !s1_ld;

	always_comb begin
		if (cfg.warmup_length != '0 && step_s1 <= cfg.warmup_length) begin
			ph_next = wcrs_pkg::PH_WARMUP;
		end else if (cfg.decay_end == '0) begin
			ph_next = wcrs_pkg::PH_PEAK;
		end else if (step_s1 >= cfg.decay_end) begin
			ph_next = wcrs_pkg::PH_FLOOR;
		end else begin
			ph_next = wcrs_pkg::PH_DECAY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (s1_ld) begin
				vld_s1 <= start;
			end
			if (s2_ld) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ld && start) begin
			step_s1 <= step_number;
		end
		if (s2_ld && vld_s1) begin
			step_s2 <= step_s1;
			ph_s2   <= ph_next;
			d_s2    <= step_s1 - cfg.warmup_length;
			span_s2 <= cfg.decay_end - cfg.warmup_length;
		end
	end

	assign warm_prod = 64'(cfg.peak_rate) * 64'(step_s2);
	assign decay_num = (64'(d_s2) * 64'(TABLE_ENTRIES)) << wcrs_pkg::FRAC_W;

	assign job_valid = vld_s2;

	always_comb begin
		job.phase = ph_s2;
		if (ph_s2 == wcrs_pkg::PH_WARMUP) begin
			job.dividend = warm_prod;
			job.divisor  = cfg.warmup_length;
		end else begin
			job.dividend = decay_num;
			job.divisor  = span_s2;
		end
	end

endmodule

/* rtl/wcrs_div.sv */
// pipelined restoring divider, one quotient bit per stage
module wcrs_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  wcrs_pkg::phase_t              in_phase,
	input  logic [wcrs_pkg::DIVD_W-1:0]   in_dividend,
	input  logic [wcrs_pkg::RATE_W-1:0]   in_divisor,
	output logic                          out_valid,
	output wcrs_pkg::phase_t              out_phase,
	output logic [wcrs_pkg::RATE_W-1:0]   out_quot
);

	localparam int unsigned STEPS = wcrs_pkg::RATE_W;
	localparam int unsigned W = wcrs_pkg::RATE_W;

	logic                   vld_s [STEPS];
	wcrs_pkg::phase_t       ph_s  [STEPS];
	logic [2*W-1:0]         rq_s  [STEPS];
	logic [W-1:0]           dv_s  [STEPS];
	logic                   vld_in [STEPS];
	wcrs_pkg::phase_t       ph_in  [STEPS];
	logic [2*W-1:0]         rq_in  [STEPS];
	logic [W-1:0]           dv_in  [STEPS];

	function automatic logic [2*W-1:0] div_step(input logic [2*W-1:0] rq,
		input logic [W-1:0] dv);
		logic [W:0] cand;
		logic [W:0] diff;
		cand = rq[2*W-1:W-1];
		diff = cand - {1'b0, dv};
		if (cand >= {1'b0, dv}) begin
			div_step = {diff[W-1:0], rq[W-2:0], 1'b1};
		end else begin
			div_step = {cand[W-1:0], rq[W-2:0], 1'b0};
		end
	endfunction

	assign vld_in[0] = in_valid;
	assign ph_in[0]  = in_phase;
	assign rq_in[0]  = in_dividend;
	assign dv_in[0]  = in_divisor;

	for (genvar k = 1; k < STEPS; k++) begin : g_link
		assign vld_in[k] = vld_s[k-1];
		assign ph_in[k]  = ph_s[k-1];
		assign rq_in[k]  = rq_s[k-1];
		assign dv_in[k]  = dv_s[k-1];
	end

	for (genvar k = 0; k < STEPS; k++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_in[k];
			end
		end

		always_ff @(posedge clk) begin
			ph_s[k] <= ph_in[k];
			rq_s[k] <= div_step(rq_in[k], dv_in[k]);
			dv_s[k] <= dv_in[k];
		end
	end

	assign out_valid = vld_s[STEPS-1];
	assign out_phase = ph_s[STEPS-1];
	assign out_quot  = rq_s[STEPS-1][W-1:0];

endmodule

/* rtl/wcrs_back.sv */
// back end: divider, half-cosine rom, interpolation and blend
module wcrs_back #(
	parameter int unsigned TABLE_ENTRIES = wcrs_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wcrs_pkg::cfg_t                cfg,
	input  logic                          in_valid,
	input  wcrs_pkg::job_t                in_job,
	output logic                          done,
	output logic [wcrs_pkg::RATE_W-1:0]   rate,
	output wcrs_pkg::phase_t              phase
);

	localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES + 1);
	localparam int unsigned W = wcrs_pkg::RATE_W;
	localparam int unsigned F = wcrs_pkg::FRAC_W;

	typedef logic [W:0] rom_t [0:TABLE_ENTRIES];

	function automatic rom_t build_rom();
		rom_t        r;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] p;
		for (int i = 0; i <= TABLE_ENTRIES / 2; i++) begin
			x  = (wcrs_pkg::PI_Q31 * 64'(i)) / 64'(TABLE_ENTRIES);
			x2 = (x * x) >> 31;
			t  = wcrs_pkg::Q31_ONE;
			for (int k = 0; k < wcrs_pkg::HORNER_N; k++) begin
				p = ((x2 * t) >> 31) / 64'(wcrs_pkg::HORNER_DIV[k]);
				t = (p > wcrs_pkg::Q31_ONE) ? 64'd0 : (wcrs_pkg::Q31_ONE - p);
			end
			r[i] = (W+1)'(wcrs_pkg::Q31_ONE + t);
		end
		for (int i = TABLE_ENTRIES / 2 + 1; i <= TABLE_ENTRIES; i++) begin
			r[i] = wcrs_pkg::Q32_ONE - r[TABLE_ENTRIES - i];
		end
		return r;
	endfunction

	localparam rom_t ROM = build_rom();

	logic                 dv_valid;
	wcrs_pkg::phase_t     dv_phase;
	logic [W-1:0]         dv_quot;
	logic [IDX_W-1:0]     idx;
	logic [IDX_W-1:0]     idx_nx;

	logic                 vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	wcrs_pkg::phase_t     ph_s1, ph_s2, ph_s3, ph_s4, ph_s5;
	logic [W-1:0]         quot_s1, quot_s2, quot_s3, quot_s4, quot_s5;
	logic [W:0]           v0_s1, v1_s1, v0_s2, v0_s3;
	logic [F-1:0]         f_s1, f_s2;
	logic                 up_s2, up_s3;
	logic [W:0]           diff_s2;
	logic [W+F:0]         prod_s3;
	logic [W:0]           c_s4;
	logic [W-1:0]         span_s4;
	logic [2*W:0]         prod_s5;
	logic [W-1:0]         blend;
	logic [W-1:0]         decay_rate;

	logic                 done_q;
	logic [W-1:0]         rate_q;
	wcrs_pkg::phase_t     phase_q;

	wcrs_div u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_phase    (in_job.phase),
		.in_dividend (in_job.dividend),
		.in_divisor  (in_job.divisor),
		.out_valid   (dv_valid),
		.out_phase   (dv_phase),
		.out_quot    (dv_quot)
	);

	assign idx    = IDX_W'(dv_quot >> F);
	assign idx_nx = idx + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= dv_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			done_q <= vld_s5;
		end
	end

	// rom read, then slope, product, interpolated factor, blend product
	always_ff @(posedge clk) begin
		ph_s1   <= dv_phase;
		quot_s1 <= dv_quot;
		v0_s1   <= ROM[idx];
		v1_s1   <= ROM[idx_nx];
		f_s1    <= dv_quot[F-1:0];

		ph_s2   <= ph_s1;
		quot_s2 <= quot_s1;
		v0_s2   <= v0_s1;
		f_s2    <= f_s1;
		up_s2   <= (v1_s1 > v0_s1);
		diff_s2 <= (v1_s1 > v0_s1) ? (v1_s1 - v0_s1) : (v0_s1 - v1_s1);

		ph_s3   <= ph_s2;
		quot_s3 <= quot_s2;
		v0_s3   <= v0_s2;
		up_s3   <= up_s2;
		prod_s3 <= (W+F+1)'(diff_s2) * (W+F+1)'(f_s2);

		ph_s4   <= ph_s3;
		quot_s4 <= quot_s3;
		c_s4    <= up_s3 ? (v0_s3 + prod_s3[W+F:F]) : (v0_s3 - prod_s3[W+F:F]);
		span_s4 <= (cfg.peak_rate >= cfg.floor_rate) ? (cfg.peak_rate - cfg.floor_rate)
			: (cfg.floor_rate - cfg.peak_rate);

		ph_s5   <= ph_s4;
		quot_s5 <= quot_s4;
		prod_s5 <= (2*W+1)'(span_s4) * (2*W+1)'(c_s4);

		phase_q <= ph_s5;
		case (ph_s5)
			wcrs_pkg::PH_WARMUP: rate_q <= quot_s5;
			wcrs_pkg::PH_DECAY:  rate_q <= decay_rate;
			wcrs_pkg::PH_FLOOR:  rate_q <= cfg.floor_rate;
			wcrs_pkg::PH_PEAK:   rate_q <= cfg.peak_rate;
			default:             rate_q <= decay_rate;
		endcase
	end

	assign blend      = prod_s5[2*W-1:W];
	assign decay_rate = (cfg.peak_rate >= cfg.floor_rate) ? (cfg.floor_rate + blend)
		: (cfg.floor_rate - blend);

	assign done  = done_q;
	assign rate  = rate_q;
	assign phase = phase_q;

endmodule

/* rtl/warmup_cosine_rate_schedule.sv */
// top level of the warmup cosine rate schedule
// Usage: raise start with a step number while busy is low and the beat is
// taken at that clock edge. One result beat per step comes back on rate and
// phase, marked by a one-cycle done strobe.
// A new step may be given every cycle while busy is low, so throughput is
// one step per cycle. A step passes two front stages, one queue slot, the
// 32-stage restoring divider in the back end and six rom, interpolation and
// blend stages. Results leave in the order the steps were taken.
// Registers are written through cfg_valid/cfg_ready with cfg_index and
// cfg_data; cfg_ready is always high. Write them only while no step is in
// flight. Index 0 peak rate, 1 floor rate, 2 warmup length, 3 decay end.
// Reset clears all registers to zero and empties the pipeline; the half-cosine
// rom is fixed and needs no loading. The receiver cannot stall, so done is
// never held; busy only rises if the front-to-back queue were to fill.
module warmup_cosine_rate_schedule #(
	parameter int unsigned TABLE_ENTRIES = wcrs_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [wcrs_pkg::RATE_W-1:0]   step_number,
	output logic                          busy,
	output logic                          done,
	output logic [wcrs_pkg::RATE_W-1:0]   rate,
	output logic [1:0]                    phase,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [1:0]                    cfg_index,
	input  logic [wcrs_pkg::RATE_W-1:0]   cfg_data
);

	localparam int unsigned LATENCY = 9 + wcrs_pkg::RATE_W;

	wcrs_pkg::cfg_t                 cfg_q;
	logic                           job_valid;
	wcrs_pkg::job_t                 job;
	logic                           q_full;
	logic                           q_empty;
	wcrs_pkg::job_t                 q_head;
	logic [wcrs_pkg::QCNT_W-1:0]    q_count;
	wcrs_pkg::phase_t               out_phase;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (wcrs_pkg::reg_idx_t'(cfg_index))
				wcrs_pkg::REG_PEAK:   cfg_q.peak_rate     <= cfg_data;
				wcrs_pkg::REG_FLOOR:  cfg_q.floor_rate    <= cfg_data;
				wcrs_pkg::REG_WARMUP: cfg_q.warmup_length <= cfg_data;
				wcrs_pkg::REG_DECAY:  cfg_q.decay_end     <= cfg_data;
				default:              cfg_q <= cfg_q;
			endcase
		end
	end

	wcrs_front #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.step_number (step_number),
		.busy        (busy),
		.cfg         (cfg_q),
		.job_valid   (job_valid),
		.job         (job),
		.job_ready   (!q_full)
	);

	wcrs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_valid),
		.push_job (job),
		.full     (q_full),
		.pop      (!q_empty),
		.head     (q_head),
		.empty    (q_empty),
		.count    (q_count)
	);

	wcrs_back #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (!q_empty),
		.in_job   (q_head),
		.done     (done),
		.rate     (rate),
		.phase    (out_phase)
	);

	assign phase = out_phase;

	// the back drains every cycle, so the queue never holds more than one job
	a_queue_shallow: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= wcrs_pkg::QCNT_W'(1))
		else $error("job queue holds more than one job");

	a_step_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("step beat without result beat");

	a_result_has_step: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result beat without step beat");

endmodule

/* tb/sv/warmup_cosine_rate_schedule_tb.sv */
// self-checking testbench of the warmup cosine rate schedule with its own rate predictor
module warmup_cosine_rate_schedule_tb;

	localparam int unsigned ENTRIES = 1024;
	localparam int unsigned LATENCY = 41;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [31:0] step_number = '0;
	logic        busy;
	logic        done;
	logic [31:0] rate;
	logic [1:0]  phase;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = wcrs_pkg::REG_PEAK;
	logic [31:0] cfg_data = '0;

	typedef struct {
		logic [31:0]      rate;
		wcrs_pkg::phase_t phase;
	} sched_t;

	logic [32:0] cos_rom [ENTRIES+1];
	logic [31:0] peak_q, floor_q, warm_len, dec_end;
	sched_t      rate_queue[$];
	int          errors = 0;
	int          beats_in = 0;
	int          beats_out = 0;
	int          send_gap_pct = 0;

	warmup_cosine_rate_schedule u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .step_number(step_number),
		.busy(busy), .done(done), .rate(rate), .phase(phase),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#4_000_000;
		$display("timeout");
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic logic [32:0] half_cos(longint unsigned i);
		longint unsigned x, x2, t, p;
		int unsigned divs [7];
		divs = '{182, 132, 90, 56, 30, 12, 2};
		x = (64'd6746518852 * i) / ENTRIES;
		x2 = (x * x) >> 31;
		t = 64'h8000_0000;
		for (int k = 0; k < 7; k++) begin
			p = ((x2 * t) >> 31) / divs[k];
			t = (p > 64'h8000_0000) ? 64'd0 : 64'h8000_0000 - p;
		end
		return 33'(64'h8000_0000 + t);
	endfunction

	function automatic sched_t predict_rate(logic [31:0] stp);
		sched_t r;
		longint unsigned d, s, q, idx, f, v0, v1, c, st;
		st = stp;
		if (warm_len != 0 && stp <= warm_len) begin
			r.rate = 32'((64'(peak_q) * st) / warm_len);
			r.phase = wcrs_pkg::PH_WARMUP;
		end else if (dec_end == 0) begin
			r.rate = peak_q;
			r.phase = wcrs_pkg::PH_PEAK;
		end else if (stp >= dec_end) begin
			r.rate = floor_q;
			r.phase = wcrs_pkg::PH_FLOOR;
		end else begin
			d = st - warm_len;
			s = 64'(dec_end) - warm_len;
			q = d * ENTRIES;
			idx = q / s;
			f = ((q % s) << 16) / s;
			if (idx > ENTRIES - 1) idx = ENTRIES - 1;
			v0 = cos_rom[idx];
			v1 = cos_rom[idx+1];
			if (v0 >= v1) c = v0 - (((v0 - v1) * f) >> 16);
			else c = v0 + (((v1 - v0) * f) >> 16);
			if (peak_q >= floor_q)
				r.rate = 32'(floor_q + (((64'(peak_q) - floor_q) * c) >> 32));
			else
				r.rate = 32'(floor_q - (((64'(floor_q) - peak_q) * c) >> 32));
			r.phase = wcrs_pkg::PH_DECAY;
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("mismatch %s: got %0h want %0h", what, got, want);
	endtask

	always @(posedge clk) begin
		sched_t e;
		if (arst_n && done) begin
			beats_out++;
			if (rate_queue.size() == 0) begin
				report_mismatch("unexpected beat", rate, 32'd0);
			end else begin
				e = rate_queue.pop_front();
				if (rate !== e.rate) report_mismatch("rate", rate, e.rate);
				if (phase !== e.phase) report_mismatch("phase", 32'(phase), 32'(e.phase));
			end
		end
	end

	// start stays high after the beat until the next gap or drain lowers it
	task automatic send_step(logic [31:0] stp);
		while ($urandom_range(99) < send_gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		step_number <= stp;
		do @(posedge clk); while (busy);
		rate_queue.push_back(predict_rate(stp));
		beats_in++;
	endtask

	task automatic drain;
		start <= 1'b0;
		while (rate_queue.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_reg(wcrs_pkg::reg_idx_t idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			wcrs_pkg::REG_PEAK:   peak_q = val;
			wcrs_pkg::REG_FLOOR:  floor_q = val;
			wcrs_pkg::REG_WARMUP: warm_len = val;
			wcrs_pkg::REG_DECAY:  dec_end = val;
			default: ;
		endcase
	endtask

	task automatic set_schedule(logic [31:0] pk, logic [31:0] fl, logic [31:0] wu,
			logic [31:0] de);
		drain();
		write_reg(wcrs_pkg::REG_PEAK, pk);
		write_reg(wcrs_pkg::REG_FLOOR, fl);
		write_reg(wcrs_pkg::REG_WARMUP, wu);
		write_reg(wcrs_pkg::REG_DECAY, de);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_reset_values;
		send_step(32'd0);
		send_step(32'hFFFF_FFFF);
	endtask

	task automatic test_directed;
		set_schedule(32'hFFFF_FFFF, 32'd0, 32'd100, 32'd1124);
		send_step(32'd0); send_step(32'd1); send_step(32'd100); send_step(32'd101);
		send_step(32'd612); send_step(32'd1123); send_step(32'd1124);
		send_step(32'hFFFF_FFFF);
		set_schedule(32'h8000_0000, 32'h1000_0000, 32'd0, 32'd0);
		send_step(32'd0); send_step(32'hFFFF_FFFF);
		set_schedule(32'h8000_0000, 32'h1000_0000, 32'd0, 32'hFFFF_FFFF);
		send_step(32'd0); send_step(32'h7FFF_FFFF); send_step(32'hFFFF_FFFE);
		send_step(32'hFFFF_FFFF);
		set_schedule(32'h1000_0000, 32'hF000_0000, 32'hFFFF_FFFF, 32'd5);
		send_step(32'hFFFF_FFFF); send_step(32'hAAAA_5555);
		set_schedule(32'h1000_0000, 32'hF000_0000, 32'd3, 32'd2);
		send_step(32'd3); send_step(32'd4); send_step(32'h5555_AAAA);
	endtask

	task automatic test_random_phase(int unsigned n);
		logic [31:0] pk, fl, wu, de, stp;
		for (int unsigned b = 0; b < n; b += 50) begin
			pk = $urandom;
			fl = ($urandom_range(9) == 0) ? $urandom : $urandom_range(pk);
			wu = ($urandom_range(4) == 0) ? 32'd0 :
				($urandom_range(1) ? $urandom_range(2000) : $urandom);
			case ($urandom_range(5))
				0: de = 32'd0;
				1: de = $urandom;
				default: de = (wu > 32'hFFF0_0000) ? 32'hFFFF_FFFF :
					wu + 1 + $urandom_range(($urandom_range(1)) ? 5000 : 32'h0FFF_FFFF);
			endcase
			set_schedule(pk, fl, wu, de);
			for (int k = 0; k < 50; k++) begin
				case ($urandom_range(3))
					0: stp = $urandom;
					1: stp = $urandom_range(wu);
					default: stp = (de > wu) ? wu + $urandom_range(de - wu) : $urandom;
				endcase
				send_step(stp);
			end
		end
	endtask

	initial begin
		for (int i = 0; i <= ENTRIES / 2; i++) cos_rom[i] = half_cos(i);
		for (int i = ENTRIES / 2 + 1; i <= ENTRIES; i++)
			cos_rom[i] = 33'h1_0000_0000 - cos_rom[ENTRIES - i];
		peak_q = '0; floor_q = '0; warm_len = '0; dec_end = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_gap_pct = 11;
		test_reset_values();
		test_directed();
		test_random_phase(550);
		send_gap_pct = 59;
		test_random_phase(550);
		send_gap_pct = 0;
		test_random_phase(550);
		drain();
		$display("steps sent %0d, rate beats checked %0d", beats_in, beats_out);
		$display("covered warmup, decay, floor and constant peak with varied gaps");
		if (errors == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
